FILE: rtl/calendar_date_to_epoch_assert.svh
// Assertion macros for the calendar date to epoch block.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef CALENDAR_DATE_TO_EPOCH_ASSERT_SVH
`define CALENDAR_DATE_TO_EPOCH_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CDE_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CDE_ASSERT(lbl, prop, msg) \
   `CDE_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define CDE_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define CDE_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: rtl/cde_pkg.sv
// Types, constants and helper functions for the calendar date to epoch block.
// No dependencies.
package cde_pkg;

   localparam int unsigned YEAR_W   = 8;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;
   localparam int unsigned ZONE_W   = 11;
   localparam int unsigned ERR_W    = 3;
   localparam int unsigned DOY_W    = 9;
   localparam int unsigned DOW_W    = 3;
   localparam int unsigned EPOCH_W  = 34;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 56;

   localparam logic [YEAR_W-1:0]   EPOCH_YEAR_OFS  = 8'd70;
   localparam logic [YEAR_W-1:0]   NOLEAP_CENTURY  = 8'd200;
   localparam logic [YEAR_W-1:0]   AFTER_CENTURY   = 8'd201;
   localparam logic [5:0]          LEAPS_TO_EPOCH  = 6'd17;
   localparam logic [MONTH_W-1:0]  MONTH_JAN       = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTH_FEB       = 4'd2;
   localparam logic [MONTH_W-1:0]  MONTH_DEC       = 4'd12;
   localparam logic [HOUR_W-1:0]   HOUR_MAX        = 5'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX      = 6'd59;
   localparam logic [SECOND_W-1:0] SECOND_MAX      = 6'd59;
   localparam logic [34:0]         SECS_PER_YEAR   = 35'd31536000;
   localparam logic [34:0]         SECS_PER_DAY    = 35'd86400;
   localparam logic [34:0]         SECS_PER_HOUR   = 35'd3600;
   localparam logic [34:0]         SECS_PER_MINUTE = 35'd60;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE   = 3'd0,
      ERR_MONTH  = 3'd1,
      ERR_DAY    = 3'd2,
      ERR_HOUR   = 3'd3,
      ERR_MINUTE = 3'd4,
      ERR_SECOND = 3'd5
   } error_code_type;

   typedef struct packed {
      error_code_type     err;
      logic [DOY_W-1:0]   doy;
      logic [DOW_W-1:0]   dow;
      logic               leap;
      logic               post_epoch;
      logic [YEAR_W-1:0]  year_offset;
      logic [DOY_W-1:0]   day_offset;
   } date_info_type;

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] mon,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      unique case (mon)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] mon);
      logic [DOY_W-1:0] d;
      unique case (mon)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Fold octal digits, since 8 is 1 mod 7
   function automatic logic [DOW_W-1:0] mod7(input logic [9:0] x);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
      s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
      return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : 3'(s2);
   endfunction

endpackage

FILE: rtl/cde_date_decode.sv
// Field checks, leap test, day of year and weekday for one date.
// Depends on cde_pkg.
module cde_date_decode
   import cde_pkg::*;
(
   input  logic [YEAR_W-1:0]   year_since_1900,
   input  logic [MONTH_W-1:0]  month_number,
   input  logic [DAY_W-1:0]    day_of_month,
   input  logic [HOUR_W-1:0]   hour_value,
   input  logic [MINUTE_W-1:0] minute_value,
   input  logic [SECOND_W-1:0] second_value,
   output date_info_type       info
);

   logic             leap;
   logic [DAY_W-1:0] lim;
   logic [DOY_W-1:0] doy;
   logic [5:0]       leaps_1901;
   error_code_type   err;

   always_comb begin
      leap = (year_since_1900[1:0] == 2'b00) && (year_since_1900 != '0) &&
             (year_since_1900 != NOLEAP_CENTURY);
      lim  = month_length(month_number, leap);

      priority if (month_number < MONTH_JAN || month_number > MONTH_DEC) begin
         err = ERR_MONTH;
      end else if (day_of_month == '0 || day_of_month > lim) begin
         err = ERR_DAY;
      end else if (hour_value > HOUR_MAX) begin
         err = ERR_HOUR;
      end else if (minute_value > MINUTE_MAX) begin
         err = ERR_MINUTE;
      end else if (second_value > SECOND_MAX) begin
         err = ERR_SECOND;
      end else begin
         err = ERR_NONE;
      end

      doy = days_before_month(month_number) +
            DOY_W'(leap && (month_number > MONTH_FEB)) +
            DOY_W'(day_of_month) - 9'd1;

      // leap days in the years 1901 up to the year before this one
      if (year_since_1900 == '0) begin
         leaps_1901 = '0;
      end else begin
         leaps_1901 = 6'((year_since_1900 - 8'd1) >> 2) -
                      6'(year_since_1900 >= AFTER_CENTURY);
      end

      info.err         = err;
      info.leap        = (err == ERR_NONE) ? leap : 1'b0;
      info.doy         = (err == ERR_NONE) ? doy : '0;
      info.dow         = (err == ERR_NONE) ?
                         mod7(10'(year_since_1900) + 10'(leaps_1901) + 10'(doy) + 10'd1) :
                         '0;
      info.post_epoch  = (year_since_1900 >= EPOCH_YEAR_OFS);
      info.year_offset = year_since_1900 - EPOCH_YEAR_OFS;
      info.day_offset  = DOY_W'(leaps_1901 - LEAPS_TO_EPOCH) + doy;
   end

endmodule

FILE: rtl/cde_epoch_seconds.sv
// Seconds since 1970 GMT from the decoded date, time of day and zone offset.
// Depends on cde_pkg.
module cde_epoch_seconds
   import cde_pkg::*;
(
   input  date_info_type        info,
   input  logic [HOUR_W-1:0]    hour_value,
   input  logic [MINUTE_W-1:0]  minute_value,
   input  logic [SECOND_W-1:0]  second_value,
   input  logic signed [ZONE_W-1:0] zone_offset_minutes,
   output logic [EPOCH_W-1:0]   epoch_seconds
);

   logic [34:0]        pos_secs;
   logic signed [17:0] zone_secs;
   logic [35:0]        total;

   always_comb begin
      pos_secs  = 35'(info.year_offset) * SECS_PER_YEAR +
                  35'(info.day_offset) * SECS_PER_DAY +
                  35'(hour_value) * SECS_PER_HOUR +
                  35'(minute_value) * SECS_PER_MINUTE +
                  35'(second_value);
      zone_secs = 18'(zone_offset_minutes) * 18'sd60;
      total     = {1'b0, pos_secs} + {{18{zone_secs[17]}}, zone_secs};
      if (info.err == ERR_NONE && info.post_epoch) begin
         epoch_seconds = total[EPOCH_W-1:0];
      end else begin
         epoch_seconds = '0;
      end
   end

endmodule

FILE: rtl/calendar_date_to_epoch.sv
// Calendar date to epoch converter: top level with input and result registers.
// Depends on cde_pkg, cde_date_decode, cde_epoch_seconds and the assertion macros.
//
// Usage:
//   req_* carries one broken-down date and time per word; rsp_* returns one
//   word per request with the error code, day of year, weekday, leap flag
//   and seconds since 1970 GMT. csr_wr_en writes the zone offset (minutes
//   west of GMT) from csr_wr_data; change it only while the block is idle.
//   A request is held in the input register, converted by combinational
//   logic and captured in the result register, from which the word is
//   presented on rsp_*. One word can be taken every cycle while the
//   receiver keeps rsp_tready high. Between the input and result
//   registers the seconds count is a constant multiply-add tree. If the
//   receiver stalls, the result register holds and the input register
//   still takes one more word; req_tready then drops until the result is
//   taken. Reset (synchronous) empties both registers and clears the zone
//   offset to zero.
`include "calendar_date_to_epoch_assert.svh"

module calendar_date_to_epoch
   import cde_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // year_since_1900[7:0], month_number[11:8], day_of_month[16:12],
   // hour_value[21:17], minute_value[27:22], second_value[33:28], zero pad
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // error_code[2:0], day_of_year[11:3], day_of_week[14:12], leap_year[15],
   // epoch_seconds[49:16], zero pad
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_wr_en,
   input  logic [ZONE_W-1:0]       csr_wr_data
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [REQ_DATA_W-1:0]   in_data_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   error_code_type          out_err_ff;
   logic [DOY_W-1:0]        out_doy_ff;
   logic [DOW_W-1:0]        out_dow_ff;
   logic                    out_leap_ff;
   logic [EPOCH_W-1:0]      out_epoch_ff;
   logic signed [ZONE_W-1:0] zone_ff;
   logic                    out_ready;
   date_info_type           info;
   logic [EPOCH_W-1:0]      epoch_secs;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_ready;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   cde_date_decode u_decode (
      .year_since_1900 (in_data_ff[7:0]),
      .month_number    (in_data_ff[11:8]),
      .day_of_month    (in_data_ff[16:12]),
      .hour_value      (in_data_ff[21:17]),
      .minute_value    (in_data_ff[27:22]),
      .second_value    (in_data_ff[33:28]),
      .info            (info)
   );

   cde_epoch_seconds u_seconds (
      .info                (info),
      .hour_value          (in_data_ff[21:17]),
      .minute_value        (in_data_ff[27:22]),
      .second_value        (in_data_ff[33:28]),
      .zone_offset_minutes (zone_ff),
      .epoch_seconds       (epoch_secs)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         zone_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            zone_ff <= $signed(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
      if (out_ready && in_valid_ff) begin
         out_err_ff   <= info.err;
         out_doy_ff   <= info.doy;
         out_dow_ff   <= info.dow;
         out_leap_ff  <= info.leap;
         out_epoch_ff <= epoch_secs;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_epoch_ff, out_leap_ff, out_dow_ff, out_doy_ff, out_err_ff};

   `CDE_ASSERT(a_err_clears_fields, out_valid_ff && out_err_ff != ERR_NONE |-> out_doy_ff == '0 && out_dow_ff == '0 && !out_leap_ff && out_epoch_ff == '0, "error word carries nonzero fields")
   `CDE_ASSERT(a_last_day_is_leap, out_valid_ff && out_doy_ff == 9'd365 |-> out_leap_ff, "day 365 in a common year")
   `CDE_ASSERT(a_weekday_range, out_valid_ff |-> out_dow_ff <= 3'd6, "weekday out of range")
   `CDE_ASSERT(a_input_held, in_valid_ff && !out_ready |=> in_valid_ff && $stable(in_data_ff), "stalled input word lost")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for calendar_date_to_epoch: drives dates on the request stream and
// checks every result word against a scoreboard that converts the same dates itself.
// Depends on cde_pkg and the calendar_date_to_epoch RTL.

module testbench;
   import cde_pkg::*;

   typedef struct packed {
      logic [SECOND_W-1:0] second;
      logic [MINUTE_W-1:0] minute;
      logic [HOUR_W-1:0]   hour;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
   } date_word_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] secs;
      logic               leap;
      logic [DOW_W-1:0]   dow;
      logic [DOY_W-1:0]   doy;
      error_code_type     err;
   } epoch_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_wr_en;
   logic [ZONE_W-1:0]     csr_wr_data;

   bit          steady  = 1'b0;
   int unsigned rx_hold = 0;

   calendar_date_to_epoch dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic bit is_leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned month_days(int unsigned m, bit leap);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic date_word_type date_of(int y, int mo, int d, int h, int mi, int s);
      date_word_type w;
      w.year   = YEAR_W'(y);
      w.month  = MONTH_W'(mo);
      w.day    = DAY_W'(d);
      w.hour   = HOUR_W'(h);
      w.minute = MINUTE_W'(mi);
      w.second = SECOND_W'(s);
      return w;
   endfunction

   // Mostly well-formed dates, some with one field broken, the rest raw noise
   function automatic date_word_type random_date();
      date_word_type w;
      int unsigned   pick;
      int unsigned   limit;
      w    = date_word_type'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick >= 15) begin
         w.month  = MONTH_W'($urandom_range(1, 12));
         limit    = month_days(w.month, is_leap_year(1900 + w.year));
         w.day    = DAY_W'($urandom_range(1, limit));
         w.hour   = HOUR_W'($urandom_range(0, 23));
         w.minute = MINUTE_W'($urandom_range(0, 59));
         w.second = SECOND_W'($urandom_range(0, 59));
         if (pick < 30) begin
            case ($urandom_range(0, 4))
               0: w.month  = MONTH_W'($urandom_range(13, 16));
               1: w.day    = (limit < 31) ? DAY_W'($urandom_range(limit + 1, 31)) : '0;
               2: w.hour   = HOUR_W'($urandom_range(24, 31));
               3: w.minute = MINUTE_W'($urandom_range(60, 63));
               default: w.second = SECOND_W'($urandom_range(60, 63));
            endcase
         end
      end
      return w;
   endfunction

   class epoch_scoreboard;
      epoch_result_type expected_q[$];
      int               zone_minutes;
      int               failures;

      function void set_zone(logic [ZONE_W-1:0] value);
         zone_minutes = int'($signed(value));
      endfunction

      function epoch_result_type convert(date_word_type d);
         epoch_result_type r;
         int unsigned      year, limit, doy, wd, ydays;
         bit               leap;
         longint           total;
         r    = '0;
         year = 1900 + d.year;
         leap = is_leap_year(year);
         if (d.month < MONTH_JAN || d.month > MONTH_DEC) begin
            r.err = ERR_MONTH;
         end else begin
            limit = month_days(d.month, leap);
            if (d.day < 1 || d.day > limit)
               r.err = ERR_DAY;
            else if (d.hour > HOUR_MAX)
               r.err = ERR_HOUR;
            else if (d.minute > MINUTE_MAX)
               r.err = ERR_MINUTE;
            else if (d.second > SECOND_MAX)
               r.err = ERR_SECOND;
         end
         if (r.err != ERR_NONE)
            return r;
         doy = d.day - 1;
         for (int m = 1; m < d.month; m++)
            doy += month_days(m, leap);
         wd     = 4 + year + (year + 3) / 4 - (year - 1701) / 100 + (year - 1601) / 400 + 3;
         r.dow  = DOW_W'((wd + doy) % 7);
         r.doy  = DOY_W'(doy);
         r.leap = leap;
         if (year >= 1970) begin
            ydays = 365 * (year - 1970) + (year - 1) / 4 - (year - 1) / 100 + (year - 1) / 400
                    - (1969 / 4 - 1969 / 100 + 1969 / 400);
            total = longint'(ydays + doy) * 24 + longint'(d.hour);
            total = total * 60 + longint'(d.minute) + longint'(zone_minutes);
            total = total * 60 + longint'(d.second);
            r.secs = total[EPOCH_W-1:0];
         end
         return r;
      endfunction

      function void note_date(date_word_type d);
         expected_q.push_back(convert(d));
      endfunction

      function void check_word(logic [RSP_DATA_W-1:0] word);
         epoch_result_type got, exp;
         got = word[$bits(epoch_result_type)-1:0];
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result word %0h", word);
            return;
         end
         exp = expected_q.pop_front();
         if (got.err !== exp.err || got.doy !== exp.doy || got.dow !== exp.dow ||
             got.leap !== exp.leap || got.secs !== exp.secs) begin
            failures++;
            if (failures <= 10) begin
               $display("result mismatch: expected err %0d doy %0d dow %0d leap %0d secs %0h",
                        exp.err, exp.doy, exp.dow, exp.leap, exp.secs);
               $display("                 got err %0d doy %0d dow %0d leap %0d secs %0h",
                        got.err, got.doy, got.dow, got.leap, got.secs);
            end
         end
      endfunction

      function void close();
         if (expected_q.size() != 0) begin
            $display("%0d expected results never arrived", expected_q.size());
            failures += expected_q.size();
         end
      endfunction
   endclass

   epoch_scoreboard sb = new;

   task automatic send_date(date_word_type d);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(d);
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_date(d);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_zone(logic [ZONE_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_zone(value);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** calendar_date_to_epoch: FAILED **");
      $finish;
   end

   initial begin : receiver
      int unsigned gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (rx_hold != 0) begin
            gap     = rx_hold;
            rx_hold = 0;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 7);
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_word(rsp_tdata);
      end
   end

   initial begin
      int zone_plan[7];
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      zone_plan   = '{-720, 0, 1023, -1024, 720, 0, 0};
      zone_plan[5] = int'($urandom_range(0, 2047)) - 1024;
      zone_plan[6] = int'($urandom_range(0, 2047)) - 1024;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 7; p++) begin
         write_zone(ZONE_W'(zone_plan[p]));
         send_date(date_of(70, 1, 1, 0, 0, 0));
         send_date(date_of(255, 12, 31, 23, 59, 59));
         if (p == 0) begin
            send_date(date_of(69, 12, 31, 23, 59, 59));
            send_date(date_of(0, 1, 1, 0, 0, 0));
            send_date(date_of(0, 2, 29, 12, 0, 0));
            send_date(date_of(100, 2, 29, 0, 0, 0));
            send_date(date_of(200, 2, 29, 0, 0, 0));
            send_date(date_of(104, 2, 29, 6, 30, 30));
            send_date(date_of(100, 3, 1, 0, 0, 0));
            send_date(date_of(101, 3, 1, 0, 0, 0));
            send_date(date_of(120, 0, 1, 0, 0, 0));
            send_date(date_of(120, 13, 1, 0, 0, 0));
            send_date(date_of(120, 15, 31, 31, 63, 63));
            send_date(date_of(120, 4, 31, 0, 0, 0));
            send_date(date_of(120, 6, 0, 0, 0, 0));
            send_date(date_of(120, 2, 0, 31, 63, 63));
            send_date(date_of(120, 6, 15, 24, 0, 0));
            send_date(date_of(120, 6, 15, 31, 63, 63));
            send_date(date_of(120, 6, 15, 23, 60, 0));
            send_date(date_of(120, 6, 15, 23, 63, 63));
            send_date(date_of(120, 6, 15, 23, 59, 60));
            send_date(date_of(120, 6, 15, 23, 59, 63));
         end
         if (p == 1)
            rx_hold = 60;
         for (int n = 0; n < 245; n++) begin
            steady = (p == 3 && n < 80);
            if (p == 2 && n == 120)
               drain_results();
            send_date(random_date());
         end
         steady = 1'b0;
         drain_results();
      end

      repeat (10) @(posedge clock);
      sb.close();
      if (sb.failures == 0)
         $display("** calendar_date_to_epoch: PASSED **");
      else
         $display("** calendar_date_to_epoch: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cde_pkg.sv
rtl/cde_date_decode.sv
rtl/cde_epoch_seconds.sv
rtl/calendar_date_to_epoch.sv
tb/sv/testbench.sv
